// ===== design/nrb_pkg.sv =====
// Package for the n-th root bisection block: sequencer control word, flag bundle,
// operation and condition codes, and the microprogram table.
// Has no dependencies; used by nrb_seq and nth_root_bisection.
package nrb_pkg;

    localparam int FRAC_BITS_DEF = 22;
    localparam int MAX_POWER_DEF = 10;

    localparam int PC_W = 3;

    typedef logic [2:0] op_t;
    localparam op_t OP_NOP       = 3'd0;
    localparam op_t OP_LOAD      = 3'd1;
    localparam op_t OP_MID       = 3'd2;
    localparam op_t OP_MUL       = 3'd3;
    localparam op_t OP_UPDATE    = 3'd4;
    localparam op_t OP_EMIT_ROOT = 3'd5;
    localparam op_t OP_EMIT_FAIL = 3'd6;

    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER       = 3'd0;
    localparam cond_t COND_ALWAYS      = 3'd1;
    localparam cond_t COND_BAD         = 3'd2;
    localparam cond_t COND_SEARCH_DONE = 3'd3;
    localparam cond_t COND_MUL_MORE    = 3'd4;

    localparam logic [PC_W-1:0] STEP_LOAD      = 3'd0;
    localparam logic [PC_W-1:0] STEP_CHECK     = 3'd1;
    localparam logic [PC_W-1:0] STEP_MID       = 3'd2;
    localparam logic [PC_W-1:0] STEP_MUL       = 3'd3;
    localparam logic [PC_W-1:0] STEP_UPDATE    = 3'd4;
    localparam logic [PC_W-1:0] STEP_EMIT_ROOT = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT_FAIL = 3'd6;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            wait_in;
        logic            wait_out;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic out_busy;
        logic bad;
        logic search_done;
        logic mul_more;
    } seq_flags_t;

    function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD, wait_in: 1'b0, wait_out: 1'b0};
        unique case (pc)
            STEP_LOAD: begin
                w = '{op: OP_LOAD, cond: COND_NEVER, target: STEP_LOAD,
                      wait_in: 1'b1, wait_out: 1'b0};
            end
            STEP_CHECK: begin
                w = '{op: OP_NOP, cond: COND_BAD, target: STEP_EMIT_FAIL,
                      wait_in: 1'b0, wait_out: 1'b0};
            end
            STEP_MID: begin
                w = '{op: OP_MID, cond: COND_SEARCH_DONE, target: STEP_EMIT_ROOT,
                      wait_in: 1'b0, wait_out: 1'b0};
            end
            STEP_MUL: begin
                w = '{op: OP_MUL, cond: COND_MUL_MORE, target: STEP_MUL,
                      wait_in: 1'b0, wait_out: 1'b0};
            end
            STEP_UPDATE: begin
                w = '{op: OP_UPDATE, cond: COND_ALWAYS, target: STEP_MID,
                      wait_in: 1'b0, wait_out: 1'b0};
            end
            STEP_EMIT_ROOT: begin
                w = '{op: OP_EMIT_ROOT, cond: COND_ALWAYS, target: STEP_LOAD,
                      wait_in: 1'b0, wait_out: 1'b1};
            end
            STEP_EMIT_FAIL: begin
                w = '{op: OP_EMIT_FAIL, cond: COND_ALWAYS, target: STEP_LOAD,
                      wait_in: 1'b0, wait_out: 1'b1};
            end
            default: begin
                w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD,
                      wait_in: 1'b0, wait_out: 1'b0};
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/nth_root_bisection.sv =====
// N-th root by bisection: an item flagged out of range goes straight to the failure result;
// otherwise the search runs B bisection steps (B up to 32), each of them using the
// single shared 32x32 multiplier, which does one multiply per cycle.
// The next item can be taken in the cycle after the result enters the output register.
// Synchronous active-low reset clears the step counter and the output valid flag.
// Depends on nrb_pkg and nrb_seq.
module nth_root_bisection #(
    parameter int FRAC_BITS = nrb_pkg::FRAC_BITS_DEF,
    parameter int MAX_POWER = nrb_pkg::MAX_POWER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] a_value, [35:32] n_power, [39:36] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] root_value
    output logic [0:0]  m_tuser    // [0] status
);
    import nrb_pkg::*;

    localparam int CW = (FRAC_BITS + 11 > 33) ? FRAC_BITS + 11 : 33;
    localparam logic [CW-1:0] ONE_C   = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] LIMIT_C = CW'(1000) << FRAC_BITS;

    ctrl_t      ctrl;
    seq_flags_t flags;

    logic [31:0] a_reg;
    logic [3:0]  n_reg;
    logic [31:0] low_reg;
    logic [31:0] high_reg;
    logic [31:0] mid_reg;
    logic [31:0] prod_reg;
    logic [3:0]  cnt_reg;
    logic        below_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] root_reg;
    logic        status_reg;

    logic        s_fire;
    logic [63:0] product;
    logic [63:0] scaled;
    logic        over;
    logic        under;
    logic [CW-1:0] a_ext;
    logic [32:0] mid_sum;

    nrb_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .flags  (flags),
        .ctrl   (ctrl)
    );

    assign s_tready = ctrl.wait_in;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = root_reg;
    assign m_tuser  = status_reg;

    assign product = 64'(prod_reg) * 64'(mid_reg);
    assign scaled  = product >> FRAC_BITS;
    assign over    = scaled > 64'(a_reg);
    assign under   = scaled < 64'(a_reg);
    assign a_ext   = CW'(a_reg);
    assign mid_sum = {1'b0, low_reg} + {1'b0, high_reg};

    always_comb begin
        flags.in_fire     = s_fire;
        flags.out_busy    = m_tvalid_reg && !m_tready;
        flags.bad         = (a_ext < ONE_C) || (a_ext > LIMIT_C) || (n_reg == 4'd0)
                            || ({1'b0, n_reg} > 5'(MAX_POWER));
        flags.search_done = (high_reg - low_reg) <= 32'd1;
        flags.mul_more    = !over && ((5'(cnt_reg) + 5'd1) < {1'b0, n_reg});
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_LOAD: begin
                if (s_fire) begin
                    a_reg    <= s_tdata[31:0];
                    n_reg    <= s_tdata[35:32];
                    low_reg  <= '0;
                    high_reg <= s_tdata[31:0];
                end
            end
            OP_MID: begin
                mid_reg  <= mid_sum[32:1];
                prod_reg <= ONE_C[31:0];
                cnt_reg  <= '0;
            end
            OP_MUL: begin
                prod_reg  <= scaled[31:0];
                cnt_reg   <= cnt_reg + 4'd1;
                below_reg <= !over && under;
            end
            OP_UPDATE: begin
                if (below_reg) begin
                    low_reg <= mid_reg;
                end else begin
                    high_reg <= mid_reg;
                end
            end
            OP_EMIT_ROOT: begin
                if (!flags.out_busy) begin
                    root_reg   <= high_reg;
                    status_reg <= 1'b0;
                end
            end
            OP_EMIT_FAIL: begin
                if (!flags.out_busy) begin
                    root_reg   <= '0;
                    status_reg <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if ((ctrl.op == OP_EMIT_ROOT || ctrl.op == OP_EMIT_FAIL) && !flags.out_busy) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The search interval always brackets the midpoint while products are formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_MUL |-> (low_reg < mid_reg) && (mid_reg < high_reg))
        else $error("midpoint outside the search interval");

    // A flagged item carries a zero root; an accepted radicand gives a nonzero root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("flagged item with nonzero root");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata != 32'd0)
        else $error("valid item with zero root");

    // Only one item is in flight: input closes right after an item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

// ===== design/nrb_seq.sv =====
// Microprogram sequencer for the n-th root bisection block: step counter,
// table lookup and conditional jumps. Depends on nrb_pkg.
module nrb_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  nrb_pkg::seq_flags_t flags,
    output nrb_pkg::ctrl_t     ctrl
);
    import nrb_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;

    assign ctrl = rom_word(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_ALWAYS:      cond_hit = 1'b1;
            COND_BAD:         cond_hit = flags.bad;
            COND_SEARCH_DONE: cond_hit = flags.search_done;
            COND_MUL_MORE:    cond_hit = flags.mul_more;
            default:          cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        priority if (ctrl.wait_in && !flags.in_fire) begin
            pc_next = pc_reg;
        end else if (ctrl.wait_out && flags.out_busy) begin
            pc_next = pc_reg;
        end else if (cond_hit) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
